// File: hdl/ocpu_pkg.sv
// Package for the orbit camera pose update unit: item types, command and
// status structs, fixed-point helpers and the microprogram of the sequencer.
// No dependencies; every other file of the unit imports it.
`default_nettype none

package ocpu_pkg;

    // Input and result items.
    typedef struct packed {
        logic               op;
        logic        [15:0] yaw_angle;
        logic        [15:0] pitch_angle;
        logic signed [31:0] pan_x;
        logic signed [31:0] pan_y;
        logic        [31:0] orbit_distance;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_out_item;

    // Item operation codes.
    localparam logic OP_UPDATE     = 1'b0;
    localparam logic OP_SET_TARGET = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_OFFSET_X = 2'd0,
        REG_OFFSET_Y = 2'd1,
        REG_OFFSET_Z = 2'd2
    } t_reg_idx;

    // Fixed-point constants.
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] EIGHTH_TURN = 31'h2000_0000;
    localparam logic [30:0] QUART_TURN  = 31'h4000_0000;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_TRIG,
        S_POST,
        S_DONE
    } t_state;

    // Multiplier operand selection.
    typedef enum logic [4:0] {
        MUL_NONE,
        MUL_RHP,
        MUL_XX,
        MUL_X2REC,
        MUL_PREC,
        MUL_X2T,
        MUL_XT,
        MUL_PCHC,
        MUL_PSHC,
        MUL_PCHS,
        MUL_PSHS,
        MUL_SYSP,
        MUL_CYSP,
        MUL_SYCP,
        MUL_CYCP,
        MUL_CYPX,
        MUL_UP0PY,
        MUL_FW0D,
        MUL_CPPY,
        MUL_SPD,
        MUL_SYPX,
        MUL_UP2PY,
        MUL_FW2D
    } t_mul;

    // Write-back operations on the registered product.
    typedef enum logic [4:0] {
        WB_NONE,
        WB_LOAD,
        WB_X,
        WB_X2,
        WB_DIV,
        WB_S0,
        WB_C0,
        WB_FIN,
        WB_QPOS,
        WB_QNEG,
        WB_UP0,
        WB_UP2,
        WB_FW0,
        WB_FW2,
        WB_F_ADD,
        WB_F_SUB,
        WB_F_FIN,
        WB_F_ONE,
        WB_POS
    } t_wb;

    // Series divisors.
    typedef enum logic [2:0] {
        DIV_72,
        DIV_42,
        DIV_20,
        DIV_6,
        DIV_90,
        DIV_56,
        DIV_30,
        DIV_12
    } t_div;

    // One microinstruction: a multiply and a write-back of the previous product.
    typedef struct packed {
        t_mul       mul;
        t_wb        wb;
        t_div       div;
        logic [1:0] axis;
    } t_uop;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_mul       mul;
        t_wb        wb;
        t_div       div;
        logic [1:0] axis;
        logic [1:0] slot;
        logic       latch;
        logic       set_tgt;
        logic       load_out;
    } t_cmd;

    // Status toward the controller.
    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic out_free;
    } t_sts;

    localparam logic [4:0] TRIG_LAST = 5'd31;
    localparam logic [4:0] POST_LAST = 5'd16;

    function automatic t_uop mk(input t_mul m, input t_wb w, input t_div d,
                                input logic [1:0] a);
        t_uop u;
        u.mul  = m;
        u.wb   = w;
        u.div  = d;
        u.axis = a;
        return u;
    endfunction

    // Divisor and its reciprocal floor(2^32 / d).
    function automatic logic [6:0] div_den(input t_div d);
        logic [6:0] r;
        case (d)
            DIV_72:  r = 7'd72;
            DIV_42:  r = 7'd42;
            DIV_20:  r = 7'd20;
            DIV_6:   r = 7'd6;
            DIV_90:  r = 7'd90;
            DIV_56:  r = 7'd56;
            DIV_30:  r = 7'd30;
            default: r = 7'd12;
        endcase
        return r;
    endfunction

    function automatic logic [29:0] div_rcp(input t_div d);
        logic [29:0] r;
        case (d)
            DIV_72:  r = 30'd59652323;
            DIV_42:  r = 30'd102261126;
            DIV_20:  r = 30'd214748364;
            DIV_6:   r = 30'd715827882;
            DIV_90:  r = 30'd47721858;
            DIV_56:  r = 30'd76695844;
            DIV_30:  r = 30'd143165576;
            default: r = 30'd357913941;
        endcase
        return r;
    endfunction

    // Sine and cosine of one angle: fold, scale, square, then two Horner series.
    function automatic t_uop trig_uop(input logic [4:0] pc);
        t_uop u;
        case (pc)
            5'd0:    u = mk(MUL_NONE,  WB_LOAD, DIV_72, 2'd0);
            5'd1:    u = mk(MUL_RHP,   WB_NONE, DIV_72, 2'd0);
            5'd2:    u = mk(MUL_NONE,  WB_X,    DIV_72, 2'd0);
            5'd3:    u = mk(MUL_XX,    WB_NONE, DIV_72, 2'd0);
            5'd4:    u = mk(MUL_NONE,  WB_X2,   DIV_72, 2'd0);
            5'd5:    u = mk(MUL_X2REC, WB_NONE, DIV_72, 2'd0);
            5'd6:    u = mk(MUL_NONE,  WB_DIV,  DIV_72, 2'd0);
            5'd7:    u = mk(MUL_X2T,   WB_NONE, DIV_42, 2'd0);
            5'd8:    u = mk(MUL_PREC,  WB_NONE, DIV_42, 2'd0);
            5'd9:    u = mk(MUL_NONE,  WB_DIV,  DIV_42, 2'd0);
            5'd10:   u = mk(MUL_X2T,   WB_NONE, DIV_20, 2'd0);
            5'd11:   u = mk(MUL_PREC,  WB_NONE, DIV_20, 2'd0);
            5'd12:   u = mk(MUL_NONE,  WB_DIV,  DIV_20, 2'd0);
            5'd13:   u = mk(MUL_X2T,   WB_NONE, DIV_6,  2'd0);
            5'd14:   u = mk(MUL_PREC,  WB_NONE, DIV_6,  2'd0);
            5'd15:   u = mk(MUL_NONE,  WB_DIV,  DIV_6,  2'd0);
            5'd16:   u = mk(MUL_XT,    WB_NONE, DIV_90, 2'd0);
            5'd17:   u = mk(MUL_NONE,  WB_S0,   DIV_90, 2'd0);
            5'd18:   u = mk(MUL_X2REC, WB_NONE, DIV_90, 2'd0);
            5'd19:   u = mk(MUL_NONE,  WB_DIV,  DIV_90, 2'd0);
            5'd20:   u = mk(MUL_X2T,   WB_NONE, DIV_56, 2'd0);
            5'd21:   u = mk(MUL_PREC,  WB_NONE, DIV_56, 2'd0);
            5'd22:   u = mk(MUL_NONE,  WB_DIV,  DIV_56, 2'd0);
            5'd23:   u = mk(MUL_X2T,   WB_NONE, DIV_30, 2'd0);
            5'd24:   u = mk(MUL_PREC,  WB_NONE, DIV_30, 2'd0);
            5'd25:   u = mk(MUL_NONE,  WB_DIV,  DIV_30, 2'd0);
            5'd26:   u = mk(MUL_X2T,   WB_NONE, DIV_12, 2'd0);
            5'd27:   u = mk(MUL_PREC,  WB_NONE, DIV_12, 2'd0);
            5'd28:   u = mk(MUL_NONE,  WB_DIV,  DIV_12, 2'd0);
            5'd29:   u = mk(MUL_X2T,   WB_NONE, DIV_12, 2'd0);
            5'd30:   u = mk(MUL_NONE,  WB_C0,   DIV_12, 2'd0);
            default: u = mk(MUL_NONE,  WB_FIN,  DIV_12, 2'd0);
        endcase
        return u;
    endfunction

    // Quaternion, axes, focal point and position; multiply overlaps write-back.
    function automatic t_uop post_uop(input logic [4:0] pc);
        t_uop u;
        case (pc)
            5'd0:    u = mk(MUL_PCHC,  WB_NONE,  DIV_72, 2'd0);
            5'd1:    u = mk(MUL_PSHC,  WB_QPOS,  DIV_72, 2'd0);
            5'd2:    u = mk(MUL_PCHS,  WB_QNEG,  DIV_72, 2'd1);
            5'd3:    u = mk(MUL_PSHS,  WB_QPOS,  DIV_72, 2'd2);
            5'd4:    u = mk(MUL_SYSP,  WB_QPOS,  DIV_72, 2'd3);
            5'd5:    u = mk(MUL_CYSP,  WB_UP0,   DIV_72, 2'd0);
            5'd6:    u = mk(MUL_SYCP,  WB_UP2,   DIV_72, 2'd0);
            5'd7:    u = mk(MUL_CYCP,  WB_FW0,   DIV_72, 2'd0);
            5'd8:    u = mk(MUL_CYPX,  WB_FW2,   DIV_72, 2'd0);
            5'd9:    u = mk(MUL_UP0PY, WB_F_ADD, DIV_72, 2'd0);
            5'd10:   u = mk(MUL_FW0D,  WB_F_FIN, DIV_72, 2'd0);
            5'd11:   u = mk(MUL_CPPY,  WB_POS,   DIV_72, 2'd0);
            5'd12:   u = mk(MUL_SPD,   WB_F_ONE, DIV_72, 2'd1);
            5'd13:   u = mk(MUL_SYPX,  WB_POS,   DIV_72, 2'd1);
            5'd14:   u = mk(MUL_UP2PY, WB_F_SUB, DIV_72, 2'd2);
            5'd15:   u = mk(MUL_FW2D,  WB_F_FIN, DIV_72, 2'd2);
            default: u = mk(MUL_NONE,  WB_POS,   DIV_72, 2'd2);
        endcase
        return u;
    endfunction

    // Shift right by 30, rounding half away from zero.
    function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
        logic        [65:0] m;
        logic        [65:0] s;
        logic signed [35:0] a;
        m = v[65] ? 66'(-v) : 66'(v);
        s = (m + (66'(1) << 29)) >> 30;
        a = $signed(s[35:0]);
        return v[65] ? -a : a;
    endfunction

    // Q2.30 to Q1.14, rounding half away from zero.
    function automatic logic signed [15:0] rnd16(input logic signed [37:0] v);
        logic        [37:0] m;
        logic        [37:0] s;
        logic signed [15:0] a;
        m = v[37] ? 38'(-v) : 38'(v);
        s = (m + (38'(1) << 15)) >> 16;
        a = $signed(s[15:0]);
        return v[37] ? -a : a;
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ocpu_in_if.sv
// Input channel of the orbit camera pose update unit: valid, ready, item.
// Depends on ocpu_pkg for the item type.
`default_nettype none

interface ocpu_in_if import ocpu_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: hdl/ocpu_out_if.sv
// Result channel of the orbit camera pose update unit: valid, ready, item.
// Depends on ocpu_pkg for the item type.
`default_nettype none

interface ocpu_out_if import ocpu_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: hdl/ocpu_ctrl.sv
// Sequencer of the orbit camera pose update unit: walks the microprogram
// for four sine/cosine passes and the pose pass. Depends on ocpu_pkg.
`default_nettype none

module ocpu_ctrl import ocpu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_pc, n_pc;
    logic [1:0] r_k, n_k;
    t_uop       w_uop;

    // State, program counter and angle pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_k     <= n_k;
        end
    end

    // Next state and command.
    always_comb begin
        n_state        = r_state;
        n_pc           = r_pc;
        n_k            = r_k;
        o_in_ready     = (r_state == S_IDLE);
        w_uop          = trig_uop(r_pc);
        o_cmd.mul      = MUL_NONE;
        o_cmd.wb       = WB_NONE;
        o_cmd.div      = DIV_72;
        o_cmd.axis     = 2'd0;
        o_cmd.slot     = r_k;
        o_cmd.latch    = 1'b0;
        o_cmd.set_tgt  = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    if (i_sts.in_op == OP_SET_TARGET) begin
                        o_cmd.set_tgt = 1'b1;
                    end else begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_TRIG;
                        n_pc        = '0;
                        n_k         = '0;
                    end
                end
            end
            S_TRIG: begin
                o_cmd.mul  = w_uop.mul;
                o_cmd.wb   = w_uop.wb;
                o_cmd.div  = w_uop.div;
                o_cmd.axis = w_uop.axis;
                if (r_pc == TRIG_LAST) begin
                    n_pc = '0;
                    if (r_k == 2'd3) begin
                        n_state = S_POST;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end else begin
                    n_pc = r_pc + 5'd1;
                end
            end
            S_POST: begin
                w_uop      = post_uop(r_pc);
                o_cmd.mul  = w_uop.mul;
                o_cmd.wb   = w_uop.wb;
                o_cmd.div  = w_uop.div;
                o_cmd.axis = w_uop.axis;
                if (r_pc == POST_LAST) begin
                    n_state = S_DONE;
                    n_pc    = '0;
                end else begin
                    n_pc = r_pc + 5'd1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result register is loaded only when it is free.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded while output register is occupied");

    // An accepted update item starts the first angle pass at its first step.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_sts.in_valid && i_sts.in_op == OP_UPDATE)
        |=> (r_state == S_TRIG && r_pc == 5'd0 && r_k == 2'd0))
        else $error("update item did not start the angle passes");

    // After the fourth angle pass the pose pass follows.
    a_trig_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIG && r_pc == TRIG_LAST && r_k == 2'd3)
        |=> (r_state == S_POST && r_pc == 5'd0))
        else $error("pose pass did not follow the angle passes");

    // The pose pass ends in the done state.
    a_post_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST && r_pc == POST_LAST) |=> (r_state == S_DONE))
        else $error("pose pass did not finish");

endmodule

`default_nettype wire

// File: hdl/ocpu_dp.sv
// Datapath of the orbit camera pose update unit: one shared multiplier with
// a registered product, write-back logic, focal point, offsets and result
// register. Depends on ocpu_pkg; driven by ocpu_ctrl commands.
`default_nettype none

module ocpu_dp import ocpu_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire t_cmd        i_cmd,
    input  wire t_in_item    i_item,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output t_out_item        o_out_item,
    output logic             o_out_free
);

    localparam int DROP = 31 - ANGLE_BITS;

    // Latched update fields.
    logic        [15:0] r_yaw, r_pitch;
    logic signed [31:0] r_panx, r_pany;
    logic        [31:0] r_dist;

    // Series working registers.
    logic signed [65:0] r_prod;
    logic        [29:0] r_r;
    logic        [1:0]  r_quad;
    logic               r_swap;
    logic        [30:0] r_x;
    logic        [31:0] r_x2;
    logic        [31:0] r_v;
    logic        [30:0] r_t;
    logic        [30:0] r_s0;
    logic        [30:0] r_c0;

    // Angle results and pose terms.
    logic signed [31:0] r_sn [4];
    logic signed [31:0] r_cs [4];
    logic signed [31:0] r_up0, r_up2, r_fw0, r_fw2;
    logic signed [37:0] r_acc;
    logic signed [15:0] r_quat [4];
    logic signed [31:0] r_pos [3];

    // State and configuration.
    logic signed [31:0] r_focal [3];
    logic signed [31:0] r_off [3];

    // Output register.
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic signed [32:0] w_a, w_b;
    logic        [31:0] w_phase;
    logic        [31:0] w_pm;
    logic        [30:0] w_rr;
    logic        [31:0] w_qe;
    logic        [38:0] w_qd;
    logic        [38:0] w_rem;
    logic        [31:0] w_q;
    logic        [6:0]  w_den;
    logic signed [31:0] w_fs, w_fc;
    logic signed [31:0] w_sn, w_cs;
    logic signed [37:0] w_rnd, w_neg, w_foc, w_off;
    logic signed [15:0] w_qr;

    // Multiplier operand selection.
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.mul)
            MUL_RHP:   begin w_a = {3'b0, r_r};            w_b = {2'b0, HALF_PI_Q30}; end
            MUL_XX:    begin w_a = {2'b0, r_x};            w_b = {2'b0, r_x};         end
            MUL_X2REC: begin w_a = {1'b0, r_x2};           w_b = {3'b0, div_rcp(i_cmd.div)}; end
            MUL_PREC:  begin w_a = {1'b0, r_prod[61:30]};  w_b = {3'b0, div_rcp(i_cmd.div)}; end
            MUL_X2T:   begin w_a = {1'b0, r_x2};           w_b = {2'b0, r_t};         end
            MUL_XT:    begin w_a = {2'b0, r_x};            w_b = {2'b0, r_t};         end
            MUL_PCHC:  begin w_a = 33'(r_cs[1]);           w_b = 33'(r_cs[0]);        end
            MUL_PSHC:  begin w_a = 33'(r_sn[1]);           w_b = 33'(r_cs[0]);        end
            MUL_PCHS:  begin w_a = 33'(r_cs[1]);           w_b = 33'(r_sn[0]);        end
            MUL_PSHS:  begin w_a = 33'(r_sn[1]);           w_b = 33'(r_sn[0]);        end
            MUL_SYSP:  begin w_a = 33'(r_sn[2]);           w_b = 33'(r_sn[3]);        end
            MUL_CYSP:  begin w_a = 33'(r_cs[2]);           w_b = 33'(r_sn[3]);        end
            MUL_SYCP:  begin w_a = 33'(r_sn[2]);           w_b = 33'(r_cs[3]);        end
            MUL_CYCP:  begin w_a = 33'(r_cs[2]);           w_b = 33'(r_cs[3]);        end
            MUL_CYPX:  begin w_a = 33'(r_cs[2]);           w_b = 33'(r_panx);         end
            MUL_UP0PY: begin w_a = 33'(r_up0);             w_b = 33'(r_pany);         end
            MUL_FW0D:  begin w_a = 33'(r_fw0);             w_b = {1'b0, r_dist};      end
            MUL_CPPY:  begin w_a = 33'(r_cs[3]);           w_b = 33'(r_pany);         end
            MUL_SPD:   begin w_a = 33'(r_sn[3]);           w_b = {1'b0, r_dist};      end
            MUL_SYPX:  begin w_a = 33'(r_sn[2]);           w_b = 33'(r_panx);         end
            MUL_UP2PY: begin w_a = 33'(r_up2);             w_b = 33'(r_pany);         end
            MUL_FW2D:  begin w_a = 33'(r_fw2);             w_b = {1'b0, r_dist};      end
            default:   begin w_a = '0;                     w_b = '0;                  end
        endcase
    end

    // Angle phase for the current pass, truncated and split into quadrant and remainder.
    always_comb begin
        case (i_cmd.slot)
            2'd0:    w_phase = {1'b0, r_yaw, 15'b0};
            2'd1:    w_phase = {1'b0, r_pitch, 15'b0};
            2'd2:    w_phase = {r_yaw, 16'b0};
            default: w_phase = {r_pitch, 16'b0};
        endcase
        w_pm = {w_phase[31:DROP], {DROP{1'b0}}};
        w_rr = {1'b0, w_pm[29:0]};
    end

    // Division by a series constant: reciprocal estimate plus one correction.
    always_comb begin
        w_den = div_den(i_cmd.div);
        w_qe  = r_prod[63:32];
        w_qd  = {7'b0, w_qe} * {32'b0, w_den};
        w_rem = {7'b0, r_v} - w_qd;
        w_q   = (w_rem >= {32'b0, w_den}) ? (w_qe + 32'd1) : w_qe;
    end

    // Quadrant mapping of the octant sine and cosine.
    always_comb begin
        w_fs = r_swap ? $signed({1'b0, r_c0}) : $signed({1'b0, r_s0});
        w_fc = r_swap ? $signed({1'b0, r_s0}) : $signed({1'b0, r_c0});
        case (r_quad)
            2'd0:    begin w_sn = w_fs;  w_cs = w_fc;  end
            2'd1:    begin w_sn = w_fc;  w_cs = -w_fs; end
            2'd2:    begin w_sn = -w_fs; w_cs = -w_fc; end
            default: begin w_sn = -w_fc; w_cs = w_fs;  end
        endcase
    end

    // Rounded product and the pose operands of the current axis.
    always_comb begin
        w_rnd = 38'(rnd30(r_prod));
        w_neg = -w_rnd;
        w_foc = 38'(r_focal[i_cmd.axis]);
        w_off = 38'(r_off[i_cmd.axis]);
        w_qr  = rnd16(w_rnd);
    end

    // Control state: focal point, offsets and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal[0]  <= '0;
            r_focal[1]  <= '0;
            r_focal[2]  <= '0;
            r_off[0]    <= '0;
            r_off[1]    <= '0;
            r_off[2]    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OFFSET_X: r_off[0] <= $signed(i_cfg_data);
                    REG_OFFSET_Y: r_off[1] <= $signed(i_cfg_data);
                    REG_OFFSET_Z: r_off[2] <= $signed(i_cfg_data);
                    default:      ;
                endcase
            end
            if (i_cmd.set_tgt) begin
                r_focal[0] <= i_item.target_x;
                r_focal[1] <= i_item.target_y;
                r_focal[2] <= i_item.target_z;
            end
            case (i_cmd.wb)
                WB_F_FIN: r_focal[i_cmd.axis] <= sat32(r_acc + w_rnd);
                WB_F_ONE: r_focal[i_cmd.axis] <= sat32(w_foc + w_rnd);
                default:  ;
            endcase
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers: input latch, product and write-backs.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_yaw   <= i_item.yaw_angle;
            r_pitch <= i_item.pitch_angle;
            r_panx  <= i_item.pan_x;
            r_pany  <= i_item.pan_y;
            r_dist  <= i_item.orbit_distance;
        end
        if (i_cmd.mul != MUL_NONE) begin
            r_prod <= w_a * w_b;
        end
        if (i_cmd.mul == MUL_X2REC) begin
            r_v <= r_x2;
        end else if (i_cmd.mul == MUL_PREC) begin
            r_v <= r_prod[61:30];
        end
        case (i_cmd.wb)
            WB_LOAD: begin
                r_quad <= w_pm[31:30];
                if (w_rr > EIGHTH_TURN) begin
                    r_r    <= 30'(QUART_TURN - w_rr);
                    r_swap <= 1'b1;
                end else begin
                    r_r    <= w_rr[29:0];
                    r_swap <= 1'b0;
                end
            end
            WB_X:     r_x  <= 31'(($unsigned(r_prod) + (66'(1) << 29)) >> 30);
            WB_X2:    r_x2 <= 32'(($unsigned(r_prod) + (66'(1) << 29)) >> 30);
            WB_DIV:   r_t  <= ONE_Q30 - w_q[30:0];
            WB_S0:    r_s0 <= r_prod[60:30];
            WB_C0:    r_c0 <= ONE_Q30 - r_prod[61:31];
            WB_FIN: begin
                r_sn[i_cmd.slot] <= w_sn;
                r_cs[i_cmd.slot] <= w_cs;
            end
            WB_QPOS:  r_quat[i_cmd.axis] <= w_qr;
            WB_QNEG:  r_quat[i_cmd.axis] <= -w_qr;
            WB_UP0:   r_up0 <= w_neg[31:0];
            WB_UP2:   r_up2 <= w_neg[31:0];
            WB_FW0:   r_fw0 <= w_rnd[31:0];
            WB_FW2:   r_fw2 <= w_rnd[31:0];
            WB_F_ADD: r_acc <= w_foc + w_rnd;
            WB_F_SUB: r_acc <= w_foc - w_rnd;
            WB_POS:   r_pos[i_cmd.axis] <= sat32(w_off + w_foc - w_rnd);
            default:  ;
        endcase
        if (i_cmd.load_out) begin
            r_out_item.quat_w <= r_quat[0];
            r_out_item.quat_x <= r_quat[1];
            r_out_item.quat_y <= r_quat[2];
            r_out_item.quat_z <= r_quat[3];
            r_out_item.pos_x  <= r_pos[0];
            r_out_item.pos_y  <= r_pos[1];
            r_out_item.pos_z  <= r_pos[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// File: hdl/orbit_camera_pose_update_unit.sv
// Orbit camera pose update unit, top level.
// Input items arrive on i_in (valid/ready). An update item (op 0) carries yaw
// and pitch binary angles, a pan along the right and up axes and an orbit
// distance; it yields one result item on o_out with the rotation quaternion
// in Q1.14 and the camera position in Q16.16, saturated. A set-target item
// (op 1) overwrites the stored focal point in its acceptance cycle and
// yields no result.
// Sequence: an update runs four sine/cosine passes of 32 steps each on the one
// shared multiplier, then 17 pose steps and one load step into the output
// register. The next item is accepted in the cycle after the load; the unit
// works on one update at a time.
// The output register holds a finished result while the receiver stalls; the
// unit still accepts and runs the next item and waits before loading if the
// register is still occupied.
// Reset (i_rst_n low, synchronous) clears the offsets, the focal point and
// the control state. Offsets are written through i_cfg_we/i_cfg_idx/i_cfg_data.
// Depends on ocpu_pkg, ocpu_in_if, ocpu_out_if, ocpu_ctrl and ocpu_dp.
`default_nettype none

module orbit_camera_pose_update_unit import ocpu_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    ocpu_in_if.sink          i_in,
    ocpu_out_if.source       o_out
);

    t_sts      w_sts;
    t_cmd      w_cmd;
    logic      w_in_ready;
    logic      w_out_valid;
    logic      w_out_free;
    t_out_item w_out_item;

    // Status toward the sequencer.
    assign w_sts.in_valid = i_in.valid;
    assign w_sts.in_op    = i_in.item.op;
    assign w_sts.out_free = w_out_free;

    ocpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    ocpu_dp #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_item      (i_in.item),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item),
        .o_out_free  (w_out_free)
    );

    // Channel hookup.
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.item  = w_out_item;

endmodule

`default_nettype wire
